@@ rtl/core/su3chk_pkg.sv @@
// ----------------------------------------------------------------------------
// su3chk_pkg
// Shared types and constants for the link rebuild and unitarity check core.
// ----------------------------------------------------------------------------
package su3chk_pkg;

  localparam int unsigned ElemWidth = 32;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned DevWidth  = ElemWidth - 1;
  localparam int unsigned ProdWidth = 2 * ElemWidth;
  // accumulator width: sum of up to 6 products plus the identity term
  localparam int unsigned AccWidth  = ProdWidth + 5;
  localparam int unsigned NumWords  = 18;
  localparam int unsigned AddrWidth = 5;

  localparam logic [DevWidth-1:0] TolReset = DevWidth'(1074);

  typedef enum logic [0:0] {
    REG_FORMAT = 1'b0,
    REG_TOL    = 1'b1
  } reg_idx_e;

  typedef logic signed [ElemWidth-1:0] elem_t;
  typedef logic signed [AccWidth-1:0]  acc_t;

  // one product step issued by the sequencer
  typedef struct packed {
    logic                 valid;
    logic [AddrWidth-1:0] addr_a;
    logic [AddrWidth-1:0] addr_b;
    logic                 sub;    // subtract the product
    logic                 first;  // start a new sum
    logic                 last;   // sum complete after this product
    logic                 ident;  // diagonal term: subtract the identity
    logic                 dev;    // sum is a deviation part, else rebuilt part
    logic [AddrWidth-1:0] waddr;  // destination word of a rebuilt part
  } mac_op_t;

  // round half up at the fraction point and saturate to the element range
  function automatic elem_t round_elem(input acc_t a);
    acc_t s;
    s = (a + (acc_t'(1) <<< (FracBits - 1))) >>> FracBits;
    if (s > acc_t'({1'b0, {(ElemWidth-1){1'b1}}}))
      return {1'b0, {(ElemWidth-1){1'b1}}};
    else if (s < -acc_t'({1'b0, {(ElemWidth-1){1'b1}}}) - acc_t'(1))
      return {1'b1, {(ElemWidth-1){1'b0}}};
    else
      return s[ElemWidth-1:0];
  endfunction

  // magnitude, rounded and saturated to the deviation range
  function automatic logic [DevWidth-1:0] round_dev(input acc_t a);
    acc_t m;
    acc_t s;
    m = a[AccWidth-1] ? -a : a;
    s = (m + (acc_t'(1) <<< (FracBits - 1))) >>> FracBits;
    if (s > acc_t'({(DevWidth){1'b1}}))
      return {DevWidth{1'b1}};
    else
      return s[DevWidth-1:0];
  endfunction

endpackage

@@ rtl/core/su3chk_seq.sv @@
// ----------------------------------------------------------------------------
// su3chk_seq
// Sequencer: accepts entries, issues product steps, then drains the link.
// ----------------------------------------------------------------------------
module su3chk_seq import su3chk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 link_format_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 wr_en_o,
  output logic [3:0]           wr_entry_o,
  output mac_op_t              op_o,
  input  logic                 mac_idle_i,
  output logic                 drain_o,
  output logic [AddrWidth-1:0] drain_addr_o,
  output logic [3:0]           drain_k_o,
  input  logic                 out_ready_i,
  output logic                 link_start_o
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [4:0] step_q, step_d;   // rebuild product step, 0..23
  logic       chk_q, chk_d;     // check phase
  logic [1:0] di_q, di_d;       // row i of the deviation entry
  logic [1:0] dj_q, dj_d;       // row j of the deviation entry
  logic       part_q, part_d;   // 0 real sum, 1 imaginary sum
  logic [2:0] dt_q, dt_d;       // product within a check sum, 0..5
  logic [3:0] drain_q, drain_d;

  // product step decode
  logic [3:0] ea, eb;
  logic       ar, br;
  logic       sub, first, last, ident, dev;
  logic [AddrWidth-1:0] waddr;
  logic [2:0] tr;
  logic [1:0] t;
  logic [3:0] kk;
  logic [1:0] dk;
  logic       rb_last, chk_last;

  always_comb begin
    ea = '0; eb = '0; ar = 1'b0; br = 1'b0; sub = 1'b0; first = 1'b0;
    last = 1'b0; ident = 1'b0; dev = 1'b0; waddr = '0;
    tr = '0; t = '0; kk = '0; dk = '0;
    if (!chk_q) begin
      // 6 sums of 4 products: k8 re,im ; k7 ; k6 ; rebuilt in that order
      tr = step_q[4:2];          // sum index 0..5
      t  = step_q[1:0];          // pair in bit 1, part in bit 0
      first = (t == 2'd0);
      last  = (t == 2'd3);
      case (tr[2:1])
        2'd0: begin kk = 4'd8;
          if (!t[1]) begin ea = 4'd0; eb = 4'd4; end else begin ea = 4'd1; eb = 4'd3; end
        end
        2'd1: begin kk = 4'd7;
          if (!t[1]) begin ea = 4'd2; eb = 4'd3; end else begin ea = 4'd0; eb = 4'd5; end
        end
        default: begin kk = 4'd6;
          if (!t[1]) begin ea = 4'd1; eb = 4'd5; end else begin ea = 4'd2; eb = 4'd4; end
        end
      endcase
      if (!tr[0]) begin
        // real: +pr*qr -pi*qi (minus for second pair, reversed)
        ar = t[0]; br = t[0];
        sub = t[0] ^ t[1];
      end else begin
        // imag: -(pr*qi + pi*qr) for first pair, + for second
        ar = t[0]; br = ~t[0];
        sub = ~t[1];
      end
      waddr = AddrWidth'({kk, tr[0]});
    end else begin
      // 9 entries x (re,im) x 6 products
      dk = dt_q[2:1];
      ea = 4'(di_q) * 4'd3 + 4'(dk);
      eb = 4'(dj_q) * 4'd3 + 4'(dk);
      first = (dt_q == 3'd0);
      last  = (dt_q == 3'd5);
      dev   = 1'b1;
      if (!part_q) begin
        ar = dt_q[0]; br = dt_q[0]; sub = 1'b0;
        // identity taken off once per diagonal real sum
        ident = (di_q == dj_q) && first;
      end else begin
        ar = ~dt_q[0]; br = dt_q[0]; sub = dt_q[0];
      end
    end
  end

  assign rb_last  = (step_q == 5'd23);
  assign chk_last = (di_q == 2'd2) && (dj_q == 2'd2) && part_q && (dt_q == 3'd5);

  // sequencing; after the last check sum the row counter runs on to 3
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; step_d = step_q; chk_d = chk_q;
    di_d = di_q; dj_d = dj_q; part_d = part_q; dt_d = dt_q; drain_d = drain_q;
    in_ready_o = 1'b0; wr_en_o = 1'b0; link_start_o = 1'b0;
    op_o = '0; drain_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          wr_en_o = 1'b1;
          if (4'(cnt_q + 4'd1) >= (link_format_i ? 4'd6 : 4'd9)) begin
            cnt_d = '0; step_d = '0; chk_d = !link_format_i;
            di_d = '0; dj_d = '0; part_d = 1'b0; dt_d = '0;
            state_d = ST_MAC; link_start_o = 1'b1;
          end else cnt_d = 4'(cnt_q + 4'd1);
        end
      end
      ST_MAC: begin
        op_o.valid = 1'b1;
        op_o.addr_a = AddrWidth'({ea, ar});
        op_o.addr_b = AddrWidth'({eb, br});
        op_o.sub = sub; op_o.first = first; op_o.last = last;
        op_o.ident = ident; op_o.dev = dev; op_o.waddr = waddr;
        if (!chk_q) begin
          // rebuilt words must land before any read of them: wait per sum
          step_d = 5'(step_q + 5'd1);
          if (last) state_d = ST_WAIT;
          if (rb_last) chk_d = 1'b1;
        end else begin
          if (chk_last) state_d = ST_WAIT;
          if (dt_q == 3'd5) begin
            dt_d = '0;
            part_d = ~part_q;
            if (part_q) begin
              if (dj_q == 2'd2) begin
                dj_d = '0;
                di_d = 2'(di_q + 2'd1);
              end else dj_d = 2'(dj_q + 2'd1);
            end
          end else dt_d = 3'(dt_q + 3'd1);
        end
      end
      ST_WAIT: begin
        if (mac_idle_i) begin
          if (chk_q && (di_q == 2'd3)) begin
            state_d = ST_DRAIN; drain_d = '0;
          end else state_d = ST_MAC;
        end
      end
      ST_DRAIN: begin
        drain_o = 1'b1;
        if (out_ready_i) begin
          if (drain_q == 4'd8) state_d = ST_LOAD;
          drain_d = 4'(drain_q + 4'd1);
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign wr_entry_o   = cnt_q;
  assign drain_k_o    = drain_q;
  assign drain_addr_o = AddrWidth'({drain_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; cnt_q <= '0; step_q <= '0; chk_q <= 1'b0;
      di_q <= '0; dj_q <= '0; part_q <= 1'b0; dt_q <= '0; drain_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; step_q <= step_d; chk_q <= chk_d;
      di_q <= di_d; dj_q <= dj_d; part_q <= part_d; dt_q <= dt_d;
      drain_q <= drain_d;
    end
  end

endmodule

@@ rtl/core/su3chk_mac.sv @@
// ----------------------------------------------------------------------------
// su3chk_mac
// Link memory and shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module su3chk_mac import su3chk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [3:0]           wr_entry_i,
  input  elem_t                in_real_i,
  input  elem_t                in_imag_i,
  input  mac_op_t              op_i,
  input  logic                 link_start_i,
  input  logic [DevWidth-1:0]  tol_i,
  output logic                 idle_o,
  input  logic                 drain_i,
  input  logic [AddrWidth-1:0] drain_addr_i,
  output elem_t                rd_real_o,
  output elem_t                rd_imag_o,
  output logic                 viol_o,
  output logic [DevWidth-1:0]  worst_o
);

  // two word memories, identical contents, one read port each
  elem_t mem_a [NumWords];
  elem_t mem_b [NumWords];
  elem_t rda_q, rdb_q;
  mac_op_t s1_q, s2_q;
  logic signed [ProdWidth-1:0] prod_q;
  acc_t acc_q;
  logic wb_en;
  logic [AddrWidth-1:0] wb_addr;
  elem_t wb_data;
  logic [AddrWidth-1:0] ra, rb;
  logic [DevWidth-1:0] dev_part;
  logic viol_q, viol_d;
  logic [DevWidth-1:0] worst_q, worst_d;
  logic [AddrWidth-1:0] in_addr;
  acc_t nacc;

  assign in_addr = AddrWidth'({wr_entry_i, 1'b0});
  assign ra = drain_i ? drain_addr_i : op_i.addr_a;
  assign rb = drain_i ? AddrWidth'(drain_addr_i + AddrWidth'(1)) : op_i.addr_b;

  // memory ports: input entries write two words, rebuilt parts one
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[in_addr] <= in_real_i; mem_b[in_addr] <= in_real_i;
      mem_a[in_addr + AddrWidth'(1)] <= in_imag_i;
      mem_b[in_addr + AddrWidth'(1)] <= in_imag_i;
    end else if (wb_en) begin
      mem_a[wb_addr] <= wb_data; mem_b[wb_addr] <= wb_data;
    end
    rda_q <= mem_a[ra];
    rdb_q <= mem_b[rb];
  end

  // multiply stage, then accumulate stage
  always_ff @(posedge clk_i) prod_q <= rda_q * rdb_q;

  always_comb begin
    nacc = s2_q.first ? acc_t'(0) : acc_q;
    if (s2_q.sub) nacc = nacc - acc_t'(prod_q);
    else          nacc = nacc + acc_t'(prod_q);
    if (s2_q.ident) nacc = nacc - (acc_t'(1) <<< (2 * FracBits));
  end

  always_ff @(posedge clk_i) if (s2_q.valid) acc_q <= nacc;

  // control pipe follows the read and the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0; s2_q <= '0; viol_q <= 1'b0; worst_q <= '0;
    end else begin
      s1_q <= op_i; s2_q <= s1_q; viol_q <= viol_d; worst_q <= worst_d;
    end
  end

  // finished sum sits in acc with the op one stage later
  mac_op_t s3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= '0;
    else         s3_q <= s2_q;
  end

  assign wb_en   = s3_q.valid && s3_q.last && !s3_q.dev;
  assign wb_addr = s3_q.waddr;
  assign wb_data = round_elem(acc_q);
  assign dev_part = round_dev(acc_q);

  always_comb begin
    viol_d = link_start_i ? 1'b0 : viol_q;
    worst_d = worst_q;
    if (s3_q.valid && s3_q.last && s3_q.dev) begin
      if (dev_part > tol_i) viol_d = 1'b1;
      if (dev_part > worst_q) worst_d = dev_part;
    end
  end

  assign idle_o    = !op_i.valid && !s1_q.valid && !s2_q.valid && !s3_q.valid;
  assign rd_real_o = rda_q;
  assign rd_imag_o = rdb_q;
  assign viol_o    = viol_q;
  assign worst_o   = worst_q;

endmodule

@@ rtl/core/su3_link_rebuild_unitarity_check_core.sv @@
// ----------------------------------------------------------------------------
// su3_link_rebuild_unitarity_check_core
// Rebuilds row 2 of a 3x3 complex link when compressed, checks U*U^H - I.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                   | tuser
// s_axis  | in  | elem_real, elem_imag                 | -
// m_axis  | out | out_real, out_imag, row, col, maxdev | unitarity_violation
//                                                          (tlast = last_of_link)
// Entries load one a cycle into the link memory. Once a link is in, one
// shared multiplier runs, for a compressed link only, 24 rebuild products as
// six sums, each followed by a pipeline drain, then 108 check products and
// one more drain. Nine transactions follow; since each memory read is
// registered before the output register, a new read waits until the last
// one has reached it. Throughput is set by the single multiply-accumulate
// unit. Input is taken only while loading; the last transaction may wait on
// m_axis_tready while the next link loads. Reset clears control state and
// the running maximum; configuration returns to its reset values.
module su3_link_rebuild_unitarity_check_core import su3chk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // elem_real, elem_imag
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // out_real, out_imag, row_index,
                                        // col_index, max_deviation, zero fill
  output logic          m_axis_tuser,   // unitarity_violation
  output logic          m_axis_tlast,   // last_of_link
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [30:0]   cfg_data_i
);

  logic format_q;
  logic [DevWidth-1:0] tol_q;
  logic wr_en, mac_idle, drain, link_start, drain_ready;
  logic [3:0] wr_entry, drain_k;
  logic [AddrWidth-1:0] drain_addr;
  mac_op_t op;
  elem_t rd_real, rd_imag;
  logic viol;
  logic [DevWidth-1:0] worst;
  logic out_valid_q;
  logic [3:0] out_k_q;
  elem_t out_re_q, out_im_q;
  logic out_viol_q;
  logic [DevWidth-1:0] out_worst_q;
  logic [1:0] row, col;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= 1'b1; tol_q <= TolReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FORMAT: format_q <= cfg_data_i[0];
        REG_TOL:    tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  su3chk_seq u_seq (
    .clk_i, .rst_ni, .link_format_i(format_q), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .wr_en_o(wr_en), .wr_entry_o(wr_entry), .op_o(op),
    .mac_idle_i(mac_idle), .drain_o(drain), .drain_addr_o(drain_addr),
    .drain_k_o(drain_k), .out_ready_i(drain_ready), .link_start_o(link_start)
  );

  su3chk_mac u_mac (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_entry_i(wr_entry),
    .in_real_i(s_axis_tdata[31:0]), .in_imag_i(s_axis_tdata[63:32]),
    .op_i(op), .link_start_i(link_start), .tol_i(tol_q), .idle_o(mac_idle),
    .drain_i(drain && drain_ready), .drain_addr_i(drain_addr),
    .rd_real_o(rd_real), .rd_imag_o(rd_imag), .viol_o(viol), .worst_o(worst)
  );

  // output register; memory read lands in the cycle after the drain step
  logic pend_q;
  logic [3:0] pend_k_q;
  assign drain_ready = !pend_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      pend_q <= drain && drain_ready;
      if (pend_q) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // flag and maximum travel with the entry so the next link cannot alter them
  always_ff @(posedge clk_i) begin
    if (drain && drain_ready) pend_k_q <= drain_k;
    if (pend_q) begin
      out_re_q <= rd_real; out_im_q <= rd_imag; out_k_q <= pend_k_q;
      out_viol_q <= viol; out_worst_q <= worst;
    end
  end

  // entry position
  always_comb begin
    case (out_k_q)
      4'd0:    begin row = 2'd0; col = 2'd0; end
      4'd1:    begin row = 2'd0; col = 2'd1; end
      4'd2:    begin row = 2'd0; col = 2'd2; end
      4'd3:    begin row = 2'd1; col = 2'd0; end
      4'd4:    begin row = 2'd1; col = 2'd1; end
      4'd5:    begin row = 2'd1; col = 2'd2; end
      4'd6:    begin row = 2'd2; col = 2'd0; end
      4'd7:    begin row = 2'd2; col = 2'd1; end
      default: begin row = 2'd2; col = 2'd2; end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_worst_q, col, row, out_im_q, out_re_q};
  assign m_axis_tuser  = out_viol_q;
  assign m_axis_tlast  = (out_k_q == 4'd8);

  // a stalled transaction holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("output changed while stalled");
  // running maximum never decreases
  a_worst_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    worst >= $past(worst)) else $error("maximum decreased");
  // a result is followed only after the previous one was taken
  a_pend_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(out_valid_q && !m_axis_tready)) else $error("output overrun");

endmodule
